FILE: rtl/a2vfd_pkg.sv
// package: command record, frame codes and font table for the text to display frame encoder
`default_nettype none

package a2vfd_pkg;

   localparam int CHAR_W     = 8;
   localparam int MARK_W     = 2;
   localparam int POS_W      = 5;
   localparam int LEN_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int FONT_DEPTH = 95;
   localparam int FONT_IDX_W = 7;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;
   localparam int RSP_DATA_W = 40;

   localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_DOT   = 2'd1;
   localparam logic [MARK_W-1:0] MARK_COMMA = 2'd2;

   localparam logic [BYTE_W-1:0] CMD_MODE     = 8'h0f;
   localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h8f;
   localparam logic [BYTE_W-1:0] CMD_WRITE    = 8'h40;
   localparam logic [BYTE_W-1:0] ADDR_BASE    = 8'hc0;
   localparam logic [BYTE_W-1:0] DOT_BITS     = 8'h04;
   localparam logic [BYTE_W-1:0] COMMA_BITS   = 8'h06;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TILDE   = 8'h7e;
   localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2c;

   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd1;
   localparam logic [LEN_W-1:0] LEN_GLYPH = 3'd4;

   typedef struct packed {
      logic              open;
      logic              emit;
      logic [CHAR_W-1:0] emit_code;
      logic [MARK_W-1:0] emit_mark;
      logic              fin;
      logic [CHAR_W-1:0] fin_code;
      logic [MARK_W-1:0] fin_mark;
   } cmd_type;

   localparam logic [23:0] FONT [FONT_DEPTH] = '{
      24'h000000, 24'h660002, 24'h810000, 24'h010902,
      24'hf97002, 24'hbdd002, 24'h180000, 24'h000004,
      24'h414002, 24'h212002, 24'h068001, 24'h190002,
      24'h000600, 24'h180000, 24'h000400, 24'h048000,
      24'he07900, 24'h041100, 24'h786900, 24'h707100,
      24'h981100, 24'he86001, 24'hf87800, 24'h601100,
      24'hf87900, 24'hf87100, 24'h010002, 24'h018000,
      24'h0c0001, 24'h186000, 24'h128000, 24'h700502,
      24'hf16900, 24'hf81900, 24'h797102, 24'he06800,
      24'h617102, 24'he86800, 24'he80800, 24'hf07800,
      24'h981900, 24'h616002, 24'h007900, 24'h8c0801,
      24'h806800, 24'h861900, 24'h821901, 24'he07900,
      24'hf80900, 24'he07901, 24'hf80901, 24'hf87000,
      24'h610002, 24'h807900, 24'h848800, 24'h809901,
      24'h068001, 24'h987100, 24'h64e000, 24'h414002,
      24'h020001, 24'h212002, 24'h008001, 24'h006000,
      24'h020000, 24'h086802, 24'h882802, 24'h082800,
      24'h105102, 24'h08a800, 24'h590002, 24'ha92002,
      24'h880802, 24'h000002, 24'h012802, 24'h050003,
      24'h800800, 24'h181802, 24'h080802, 24'h082802,
      24'ha90800, 24'ha90002, 24'h080800, 24'ha82002,
      24'h882800, 24'h002802, 24'h008800, 24'h009801,
      24'h068001, 24'h115100, 24'h08a000, 24'h494002,
      24'h010002, 24'h312002, 24'h1c8000
   };

   function automatic logic [23:0] font_lookup(input logic [CHAR_W-1:0] code);
      logic [FONT_IDX_W-1:0] idx;
      idx = '0;
      if (code inside {[CHAR_SPACE:CHAR_TILDE]}) begin
         idx = FONT_IDX_W'(code - CHAR_SPACE);
      end
      return FONT[idx];
   endfunction

   function automatic logic [BYTE_W-1:0] mark_bits(input logic [MARK_W-1:0] mark);
      logic [BYTE_W-1:0] bits;
      case (mark)
         MARK_DOT:   bits = DOT_BITS;
         MARK_COMMA: bits = COMMA_BITS;
         default:    bits = '0;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/a2vfd_front.sv
// front end: takes characters, merges marks into the held glyph, issues commands
`default_nettype none

module a2vfd_front
   import a2vfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [CHAR_W-1:0] req_tdata,   // char_code
   input  wire logic              req_tlast,   // string_end
   output      logic              push_valid,
   input  wire logic              push_ready,
   output      cmd_type           push_cmd
);

   logic              string_open_ff, string_open_in;
   logic              pending_valid_ff, pending_valid_in;
   logic [CHAR_W-1:0] pending_char_ff, pending_char_in;
   logic [MARK_W-1:0] pending_mark_ff, pending_mark_in;

   logic              accept;
   logic              pv;
   logic [MARK_W-1:0] pm;
   logic              is_mark;
   logic              merge;
   logic [CHAR_W-1:0] new_char;
   logic [MARK_W-1:0] new_mark;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pv       = string_open_ff && pending_valid_ff;
      pm       = string_open_ff ? pending_mark_ff : MARK_NONE;
      is_mark  = (req_tdata == CHAR_DOT) || (req_tdata == CHAR_COMMA);
      merge    = pv && (pm == MARK_NONE) && is_mark;
      new_char = merge ? pending_char_ff : req_tdata;
      new_mark = MARK_NONE;
      if (merge) begin
         new_mark = (req_tdata == CHAR_DOT) ? MARK_DOT : MARK_COMMA;
      end

      push_cmd.open      = !string_open_ff;
      push_cmd.emit      = pv && !merge;
      push_cmd.emit_code = pending_char_ff;
      push_cmd.emit_mark = pm;
      push_cmd.fin       = req_tlast;
      push_cmd.fin_code  = new_char;
      push_cmd.fin_mark  = new_mark;
      push_valid = accept && (push_cmd.open || push_cmd.emit || push_cmd.fin);

      string_open_in   = string_open_ff;
      pending_valid_in = pending_valid_ff;
      pending_char_in  = pending_char_ff;
      pending_mark_in  = pending_mark_ff;
      if (accept) begin
         pending_char_in = new_char;
         if (req_tlast) begin
            string_open_in   = 1'b0;
            pending_valid_in = 1'b0;
            pending_mark_in  = MARK_NONE;
         end else begin
            string_open_in   = 1'b1;
            pending_valid_in = 1'b1;
            pending_mark_in  = new_mark;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         string_open_ff   <= 1'b0;
         pending_valid_ff <= 1'b0;
         pending_mark_ff  <= MARK_NONE;
      end else begin
         string_open_ff   <= string_open_in;
         pending_valid_ff <= pending_valid_in;
         pending_mark_ff  <= pending_mark_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_char_ff <= pending_char_in;
   end

`ifndef SYNTH
   a_mark_needs_glyph: assert property (@(posedge clock) disable iff (reset)
      (pending_mark_ff != MARK_NONE) |-> pending_valid_ff)
      else $error("mark held without a glyph");

   a_closed_no_glyph: assert property (@(posedge clock) disable iff (reset)
      !string_open_ff |-> !pending_valid_ff)
      else $error("glyph held outside a string");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> !string_open_ff)
      else $error("string still open after its last character");
`endif

endmodule

`default_nettype wire

FILE: rtl/a2vfd_cmd_fifo.sv
// short command queue between front end and frame sequencer
`default_nettype none

module a2vfd_cmd_fifo
   import a2vfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output      logic    push_ready,
   input  wire cmd_type push_cmd,
   output      logic    pop_valid,
   input  wire logic    pop_ready,
   output      cmd_type pop_cmd
);

   cmd_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not lower the count");
`endif

endmodule

`default_nettype wire

FILE: rtl/a2vfd_back.sv
// frame sequencer: turns commands into controller frames, tracks free positions
`default_nettype none

module a2vfd_back
   import a2vfd_pkg::*;
#(
   parameter int NUM_POSITIONS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output      logic                  pop_ready,
   input  wire cmd_type               pop_cmd,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tlast
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_OPEN0 = 4'd1;
   localparam logic [3:0] ST_OPEN1 = 4'd2;
   localparam logic [3:0] ST_G1A   = 4'd3;
   localparam logic [3:0] ST_G1B   = 4'd4;
   localparam logic [3:0] ST_G2A   = 4'd5;
   localparam logic [3:0] ST_G2B   = 4'd6;
   localparam logic [3:0] ST_FILLA = 4'd7;
   localparam logic [3:0] ST_FILLB = 4'd8;

   localparam logic [POS_W-1:0] POS_FULL = POS_W'(NUM_POSITIONS);

   logic [3:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   cmd_type          cmd_ff, cmd_in;

   logic              out_valid_ff, out_valid_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] b0_ff, b0_in;
   logic [BYTE_W-1:0] b1_ff, b1_in;
   logic [BYTE_W-1:0] b2_ff, b2_in;
   logic [BYTE_W-1:0] b3_ff, b3_in;
   logic              last_ff, last_in;

   logic              adv;
   logic [3:0]        nxt;
   logic [POS_W-1:0]  pos_dec;
   logic [BYTE_W-1:0] pos_m1;
   logic [BYTE_W-1:0] addr;
   logic [CHAR_W-1:0] g_code;
   logic [MARK_W-1:0] g_mark;
   logic [23:0]       g_font;
   logic [3:0]        first_glyph;
   logic [3:0]        after_open;

   assign adv     = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_tready);
   assign pop_ready = (state_ff == ST_IDLE);
   assign pos_dec = pos_ff - 1'b1;
   assign pos_m1  = BYTE_W'(pos_dec);
   assign addr    = ADDR_BASE | ((pos_m1 << 1) + pos_m1);
   assign g_font  = font_lookup(g_code);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - LEN_W - 4 * BYTE_W){1'b0}},
                        b3_ff, b2_ff, b1_ff, b0_ff, len_ff};

   always_comb begin
      first_glyph = ST_IDLE;
      if (pop_cmd.emit && pos_ff != '0) begin
         first_glyph = ST_G1A;
      end else if (pop_cmd.fin && pos_ff != '0) begin
         first_glyph = ST_G2A;
      end
      after_open = ST_IDLE;
      if (cmd_ff.emit) begin
         after_open = ST_G1A;
      end else if (cmd_ff.fin) begin
         after_open = ST_G2A;
      end
   end

   always_comb begin
      g_code = CHAR_SPACE;
      g_mark = MARK_NONE;
      case (state_ff)
         ST_G1B: begin
            g_code = cmd_ff.emit_code;
            g_mark = cmd_ff.emit_mark;
         end
         ST_G2B: begin
            g_code = cmd_ff.fin_code;
            g_mark = cmd_ff.fin_mark;
         end
         default: begin
            g_code = CHAR_SPACE;
            g_mark = MARK_NONE;
         end
      endcase
   end

   always_comb begin
      nxt    = ST_IDLE;
      len_in = LEN_SHORT;
      b0_in  = CMD_WRITE;
      b1_in  = '0;
      b2_in  = '0;
      b3_in  = '0;
      pos_in = pos_ff;
      case (state_ff)
         ST_OPEN0: begin
            b0_in = CMD_MODE;
            nxt   = ST_OPEN1;
         end
         ST_OPEN1: begin
            b0_in = CMD_DISP_ON;
            nxt   = after_open;
         end
         ST_G1A:   nxt = ST_G1B;
         ST_G2A:   nxt = ST_G2B;
         ST_FILLA: nxt = ST_FILLB;
         ST_G1B, ST_G2B, ST_FILLB: begin
            len_in = LEN_GLYPH;
            b0_in  = addr;
            b1_in  = g_font[23:16];
            b2_in  = g_font[15:8] | mark_bits(g_mark);
            b3_in  = g_font[7:0];
            pos_in = pos_dec;
            if (pos_dec == '0) begin
               nxt = ST_IDLE;
            end else if (state_ff == ST_G1B) begin
               nxt = cmd_ff.fin ? ST_G2A : ST_IDLE;
            end else begin
               nxt = ST_FILLA;
            end
         end
         default: nxt = ST_IDLE;
      endcase
      last_in = (nxt == ST_IDLE);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == ST_IDLE) begin
         if (pop_valid) begin
            cmd_in   = pop_cmd;
            state_in = pop_cmd.open ? ST_OPEN0 : first_glyph;
         end
      end else if (adv) begin
         state_in     = nxt;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_FULL;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_IDLE && pop_valid && pop_cmd.open) begin
            pos_ff <= POS_FULL;
         end else if (adv) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (adv) begin
         len_ff  <= len_in;
         b0_ff   <= b0_in;
         b1_ff   <= b1_in;
         b2_ff   <= b2_in;
         b3_ff   <= b3_in;
         last_ff <= last_in;
      end
   end

`ifndef SYNTH
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("free position count beyond display size");

   a_glyph_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G1A || state_ff == ST_G1B || state_ff == ST_G2A ||
       state_ff == ST_G2B || state_ff == ST_FILLA || state_ff == ST_FILLB)
      |-> (pos_ff != '0))
      else $error("glyph sequenced with no free position");

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (len_ff == LEN_SHORT || len_ff == LEN_GLYPH))
      else $error("frame length neither short nor glyph");
`endif

endmodule

`default_nettype wire

FILE: rtl/ascii_to_vfd_segment_frames_core.sv
// top level: text characters in, display controller frames out
// each glyph is sent as two frames (write command then address and segments);
// a string opener adds two frames (mode set, then display on); the sequencer loads each command while idle
// the first frame of a character passes the command queue and the frame sequencer before it is valid
// input stalls only when the four-entry command queue is full
// synchronous active-high reset clears string state, queue and output; positions go full
`default_nettype none

module ascii_to_vfd_segment_frames_core
   import a2vfd_pkg::*;
#(
   parameter int NUM_POSITIONS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [CHAR_W-1:0]     req_tdata,   // char_code
   input  wire logic                  req_tlast,   // string_end
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // frame_len, first_byte, second_byte,
                                                   // third_byte, fourth_byte, zero pad
   output      logic                  rsp_tlast    // run_end
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   a2vfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   a2vfd_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   a2vfd_back #(
      .NUM_POSITIONS (NUM_POSITIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
